// ===== rtl/icr_pkg.sv =====
// Package for the interval capacity reservation block.
// Holds op and status codes, register indexes and the zone unit result type.
// No dependencies.
package icr_pkg;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int AMT_W  = 16;
    localparam int ZONE_W = 7;
    localparam int HID_W  = 8;

    localparam logic [1:0] OP_CHECK   = 2'd0;
    localparam logic [1:0] OP_RESERVE = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NO_ROOM = 3'd1;
    localparam logic [2:0] ST_PRESENT = 3'd2;
    localparam logic [2:0] ST_ABSENT  = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;

    localparam logic REG_SECTION_LENGTH = 1'b0;
    localparam logic REG_ZONES_IN_USE   = 1'b1;

    typedef struct packed {
        logic [AMT_W-1:0] sum;
        logic [AMT_W-1:0] diff;
        logic             under;
        logic             over;
    } t_zone_res;

endpackage

// ===== rtl/interval_capacity_reservation.sv =====
// Interval capacity reservation table: top level with sequencer, holder bitmap
// and configuration registers. Depends on icr_pkg, icr_zone_mem and icr_alu.
//
// One request is handled at a time. A check, or a reserve or release that
// fails, on a nonempty range of zones makes one pass over the zones that
// reads each used count through the shared zone unit to check room and
// underflow. A reserve or release that succeeds adds a second
// read-modify-write pass over the same zones, one zone per cycle through
// the store's one read port and one write port. Empty ranges and range
// errors skip the zone passes. A result still waiting at the output holds
// the block before its update pass and stalls the next request. After reset
// the used-room store is cleared zone by zone before the first request is
// accepted; configuration writes are taken at any time.
module interval_capacity_reservation
    import icr_pkg::*;
#(
    parameter int ZONE_COUNT   = 64,
    parameter int HOLDER_COUNT = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_op,
    input  logic [HID_W-1:0]  i_holder_id,
    input  logic [AMT_W-1:0]  i_amount,
    input  logic [ZONE_W-1:0] i_first_zone,
    input  logic [ZONE_W-1:0] i_last_zone,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_fits,
    output logic [2:0]        o_status
);

    localparam int AW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
    localparam int HD = (HOLDER_COUNT < 256) ? HOLDER_COUNT : 256;
    localparam int HW = $clog2(HD);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SETUP  = 6'b000100,
        S_CHECK  = 6'b001000,
        S_DECIDE = 6'b010000,
        S_UPDATE = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [AMT_W-1:0]  r_sec_len;
    logic [ZONE_W-1:0] r_zones;
    logic [HD-1:0]     r_hold;

    logic [1:0]        r_op;
    logic [HID_W-1:0]  r_hid;
    logic [AMT_W-1:0]  r_amt;
    logic [ZONE_W-1:0] r_lo, r_hi;
    logic [AMT_W-1:0]  r_limit;
    logic              r_limit_neg;
    logic              r_rng_err;
    logic              r_fail_fit;
    logic              r_under;
    logic              r_present;
    logic [7:0]        r_z;
    logic              r_pend;
    logic [AW-1:0]     r_wa;
    logic [AW-1:0]     r_ca;

    logic              r_o_valid;
    logic              r_o_fits;
    logic [2:0]        r_o_status;

    logic              cfg_wr;
    logic              in_acc;
    logic              issue;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [AMT_W-1:0]  mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [AMT_W-1:0]  mem_rdata;
    t_zone_res         zres;
    logic [AMT_W:0]    limit_full;
    logic              empty_rng;
    logic              rng_err;
    logic              hid_oob;
    logic              out_free;
    logic              upd_go;
    logic [2:0]        status;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_len <= '1;
            r_zones   <= ZONE_W'(64);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_SECTION_LENGTH: r_sec_len <= pwdata[AMT_W-1:0];
                REG_ZONES_IN_USE:   r_zones   <= pwdata[ZONE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SECTION_LENGTH: prdata = DATA_W'(r_sec_len);
            REG_ZONES_IN_USE:   prdata = DATA_W'(r_zones);
            default:            prdata = '0;
        endcase
    end

    // datapath
    icr_zone_mem #(
        .DEPTH  (ZONE_COUNT),
        .ADDR_W (AW),
        .DATA_W (AMT_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (issue),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    icr_alu u_alu (
        .i_used      (mem_rdata),
        .i_amount    (r_amt),
        .i_limit     (r_limit),
        .i_limit_neg (r_limit_neg),
        .o_res       (zres)
    );

    assign in_acc     = i_valid && (r_state == S_IDLE);
    assign o_ready    = (r_state == S_IDLE);
    assign issue      = ((r_state == S_CHECK) || (r_state == S_UPDATE)) && (r_z <= {1'b0, r_hi});
    assign mem_raddr  = AW'(r_z - 8'd1);
    assign limit_full = {1'b0, r_sec_len} - {1'b0, r_amt};
    assign empty_rng  = r_lo > r_hi;
    assign rng_err    = !empty_rng && ((r_lo == '0) || (r_hi > r_zones)
                        || (32'(r_hi) > ZONE_COUNT));
    assign hid_oob    = 32'(r_hid) >= HOLDER_COUNT;
    assign out_free   = !r_o_valid || i_ready;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wa;
        mem_wdata = (r_op == OP_RESERVE) ? zres.sum : zres.diff;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_ca;
            mem_wdata = '0;
        end else if ((r_state == S_UPDATE) && r_pend) begin
            mem_we = 1'b1;
        end
    end

    // outcome of the request, valid in S_DECIDE
    always_comb begin
        status = ST_OK;
        upd_go = 1'b0;
        if (r_rng_err) begin
            status = ST_RANGE;
        end else begin
            case (r_op)
                OP_RESERVE: begin
                    if (hid_oob) begin
                        status = ST_RANGE;
                    end else if (r_present) begin
                        status = ST_PRESENT;
                    end else if (r_fail_fit) begin
                        status = ST_NO_ROOM;
                    end else begin
                        upd_go = 1'b1;
                    end
                end
                OP_RELEASE: begin
                    if (hid_oob) begin
                        status = ST_RANGE;
                    end else if (!r_present || r_under) begin
                        status = ST_ABSENT;
                    end else begin
                        upd_go = 1'b1;
                    end
                end
                default: begin
                    status = r_fail_fit ? ST_NO_ROOM : ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_ca == AW'(ZONE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = (rng_err || empty_rng) ? S_DECIDE : S_CHECK;
            end
            S_CHECK: begin
                if (!issue && !r_pend) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (out_free) begin
                    n_state = (upd_go && !empty_rng) ? S_UPDATE : S_IDLE;
                end
            end
            S_UPDATE: begin
                if (!issue && !r_pend) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_ca      <= '0;
            r_hold    <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_o_valid && i_ready && (r_state != S_DECIDE)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_ca <= r_ca + AW'(1);
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_op  <= i_op;
                        r_hid <= i_holder_id;
                        r_amt <= i_amount;
                        r_lo  <= i_first_zone;
                        r_hi  <= i_last_zone;
                    end
                end
                S_SETUP: begin
                    r_limit     <= limit_full[AMT_W-1:0];
                    r_limit_neg <= limit_full[AMT_W];
                    r_rng_err   <= rng_err;
                    r_fail_fit  <= 1'b0;
                    r_under     <= 1'b0;
                    r_present   <= !hid_oob && r_hold[HW'(r_hid)];
                    r_z         <= 8'(r_lo);
                    r_pend      <= 1'b0;
                end
                S_CHECK: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_z <= r_z + 8'd1;
                    end
                    if (r_pend) begin
                        r_fail_fit <= r_fail_fit | zres.over;
                        r_under    <= r_under | zres.under;
                    end
                end
                S_DECIDE: begin
                    r_z    <= 8'(r_lo);
                    r_pend <= 1'b0;
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_fits   <= !r_rng_err && !r_fail_fit;
                        r_o_status <= status;
                        if (upd_go) begin
                            r_hold[HW'(r_hid)] <= (r_op == OP_RESERVE);
                        end
                    end
                end
                S_UPDATE: begin
                    r_pend <= issue;
                    if (issue) begin
                        r_z  <= r_z + 8'd1;
                        r_wa <= mem_raddr;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid  = r_o_valid;
    assign o_fits   = r_o_fits;
    assign o_status = r_o_status;

endmodule

// ===== rtl/icr_zone_mem.sv =====
// Used-room store: one write port, one read port, registered read data.
// Depends on nothing beyond its parameters.
module icr_zone_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/icr_alu.sv =====
// Shared zone unit: add, subtract and room compare for one zone per cycle.
// Depends on icr_pkg.
module icr_alu
    import icr_pkg::*;
(
    input  logic [AMT_W-1:0] i_used,
    input  logic [AMT_W-1:0] i_amount,
    input  logic [AMT_W-1:0] i_limit,
    input  logic             i_limit_neg,
    output t_zone_res        o_res
);

    logic [AMT_W:0] diff;

    // limit = capacity - amount; a zone lacks room when amount is nonzero and the limit is negative or used exceeds it
    assign diff         = {1'b0, i_used} - {1'b0, i_amount};
    assign o_res.diff   = diff[AMT_W-1:0];
    assign o_res.under  = diff[AMT_W];
    assign o_res.sum    = i_used + i_amount;
    assign o_res.over   = (i_amount != '0) && (i_limit_neg || (i_used > i_limit));

endmodule
